>>> hdl/number_to_ascii_formatter_macros.svh
// Assertion macros shared by the number to ASCII formatter modules.
`ifndef NUMBER_TO_ASCII_FORMATTER_MACROS_SVH
`define NUMBER_TO_ASCII_FORMATTER_MACROS_SVH

// Check a property on every clock edge outside reset.
`define N2A_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that expr holds in the cycle after cond.
`define N2A_ASSERT_NEXT(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) else $error(msg);

`endif

>>> hdl/n2a_pkg.sv
// Shared constants, types and functions of the number to ASCII formatter.
package n2a_pkg;

  localparam int ValueW    = 32;
  localparam int KindW     = 2;
  localparam int CountW    = 4;
  localparam int CharW     = 7;
  localparam int DigitW    = 4;
  localparam int DecDigits = 10;
  localparam int HexDigits = ValueW / DigitW;
  localparam int BcdW      = DecDigits * DigitW;
  localparam int BitCntW   = $clog2(ValueW + 1);
  localparam int LeftW     = $clog2(DecDigits + 1);

  localparam logic [KindW-1:0] KIND_DEC = 2'd0;
  localparam logic [KindW-1:0] KIND_HEX = 2'd1;
  localparam logic [KindW-1:0] KIND_FIX = 2'd2;

  localparam logic [CharW-1:0] CH_ZERO    = 7'h30;
  localparam logic [CharW-1:0] CH_UPPER_A = 7'h41;
  localparam logic [CharW-1:0] CH_X       = 7'h78;
  localparam logic [CharW-1:0] CH_MINUS   = 7'h2D;

  typedef struct packed {
    logic busy;
    logic done;
  } bcd_stat_t;

  typedef struct packed {
    logic [CharW-1:0] char_code;
    logic             last_char;
  } char_t;

  function automatic logic [CharW-1:0] digit_char(input logic [DigitW-1:0] d);
    logic [CharW-1:0] c;
    if (d < 4'd10) begin
      c = CH_ZERO + {3'b000, d};
    end else begin
      c = CH_UPPER_A + {3'b000, d} - 7'd10;
    end
    return c;
  endfunction

endpackage

>>> hdl/n2a_in_if.sv
// Request channel carrying one number and its format.
interface n2a_in_if;
  logic                         valid;
  logic                         ready;
  logic [n2a_pkg::KindW-1:0]    kind;
  logic [n2a_pkg::ValueW-1:0]   value;
  logic                         hex_prefix;
  logic [n2a_pkg::CountW-1:0]   digit_count;

  modport source (output valid, kind, value, hex_prefix, digit_count, input ready);
  modport sink (input valid, kind, value, hex_prefix, digit_count, output ready);
endinterface

>>> hdl/n2a_out_if.sv
// Character channel carrying one ASCII code and its end mark.
interface n2a_out_if;
  logic                        valid;
  logic                        ready;
  logic [n2a_pkg::CharW-1:0]   char_code;
  logic                        last_char;

  modport source (output valid, char_code, last_char, input ready);
  modport sink (input valid, char_code, last_char, output ready);
endinterface

>>> hdl/number_to_ascii_formatter.sv
// Number to ASCII formatter: takes a 32-bit value and a kind and sends its text
// one character per request, most significant first, the final one marked by
// last_char. Signed and fixed-width decimal go through a bit-serial BCD
// converter; hexadecimal skips it. After that, leading digits are dropped one
// at a time in ST_SKIP, then the characters are sent from ST_PRE and ST_DIG,
// each as the output register has room; a new number is taken once the last
// character is in the output register.
`include "number_to_ascii_formatter_macros.svh"

module number_to_ascii_formatter (
  input  logic      clk,
  input  logic      rst,
  n2a_in_if.sink    number,
  n2a_out_if.source text
);
  import n2a_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CONV = 3'd1;
  localparam logic [2:0] ST_SKIP = 3'd2;
  localparam logic [2:0] ST_PRE  = 3'd3;
  localparam logic [2:0] ST_DIG  = 3'd4;

  logic [2:0]         state;
  logic [KindW-1:0]   kind_r;
  logic [CountW-1:0]  count_r;
  logic [1:0]         pre_cnt;
  logic [LeftW-1:0]   left;
  logic [BcdW-1:0]    digits;

  logic               accept;
  logic               start;
  logic [ValueW-1:0]  bin_in;
  logic [BcdW-1:0]    bcd;
  bcd_stat_t          bcd_st;
  logic [DigitW-1:0]  top_digit;
  logic               skip;
  logic [CharW-1:0]   pre_char;
  logic               room;
  logic               push;
  char_t              odata;
  logic [CountW-1:0]  count_clamp;

  assign number.ready = (state == ST_IDLE);
  assign accept       = number.valid && number.ready;
  assign start        = accept && (number.kind == KIND_DEC || number.kind == KIND_FIX);
  assign bin_in       = (number.kind == KIND_DEC && number.value[ValueW-1]) ?
                        (~number.value + 1'b1) : number.value;

  always_comb begin
    if (number.digit_count == '0) begin
      count_clamp = CountW'(1);
    end else if (number.digit_count > CountW'(DecDigits)) begin
      count_clamp = CountW'(DecDigits);
    end else begin
      count_clamp = number.digit_count;
    end
  end

  assign top_digit = digits[BcdW-1 -: DigitW];
  assign skip      = (kind_r == KIND_FIX) ? ({1'b0, left} > {1'b0, count_r}) :
                     ((top_digit == '0) && (left > LeftW'(1)));
  assign pre_char  = (kind_r == KIND_DEC) ? CH_MINUS :
                     ((pre_cnt == 2'd2) ? CH_ZERO : CH_X);
  assign push      = room && (state == ST_PRE || state == ST_DIG);

  always_comb begin
    if (state == ST_PRE) begin
      odata.char_code = pre_char;
      odata.last_char = 1'b0;
    end else begin
      odata.char_code = digit_char(top_digit);
      odata.last_char = (left == LeftW'(1));
    end
  end

  n2a_bcd u_bcd (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .bin_in (bin_in),
    .bcd    (bcd),
    .stat   (bcd_st)
  );

  n2a_oreg u_oreg (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .data (odata),
    .room (room),
    .text (text)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      kind_r  <= KIND_DEC;
      count_r <= '0;
      pre_cnt <= '0;
      left    <= '0;
      digits  <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            kind_r  <= number.kind;
            count_r <= count_clamp;
            unique case (number.kind)
              KIND_DEC: begin
                pre_cnt <= {1'b0, number.value[ValueW-1]};
                state   <= ST_CONV;
              end
              KIND_HEX: begin
                pre_cnt <= number.hex_prefix ? 2'd2 : 2'd0;
                digits  <= {number.value, {(BcdW-ValueW){1'b0}}};
                left    <= LeftW'(HexDigits);
                state   <= ST_SKIP;
              end
              KIND_FIX: begin
                pre_cnt <= 2'd0;
                state   <= ST_CONV;
              end
              default: begin
                state <= ST_IDLE;
              end
            endcase
          end
        end
        ST_CONV: begin
          if (bcd_st.done) begin
            digits <= bcd;
            left   <= LeftW'(DecDigits);
            state  <= ST_SKIP;
          end
        end
        ST_SKIP: begin
          if (skip) begin
            digits <= {digits[BcdW-DigitW-1:0], {DigitW{1'b0}}};
            left   <= left - 1'b1;
          end else begin
            state <= (pre_cnt != 2'd0) ? ST_PRE : ST_DIG;
          end
        end
        ST_PRE: begin
          if (room) begin
            pre_cnt <= pre_cnt - 1'b1;
            if (pre_cnt == 2'd1) begin
              state <= ST_DIG;
            end
          end
        end
        ST_DIG: begin
          if (room) begin
            digits <= {digits[BcdW-DigitW-1:0], {DigitW{1'b0}}};
            left   <= left - 1'b1;
            if (left == LeftW'(1)) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `N2A_ASSERT(a_idle_bcd, (state == ST_IDLE) |-> !bcd_st.busy, "converter busy while idle")
  `N2A_ASSERT(a_left_nz, (state == ST_SKIP || state == ST_DIG) |-> (left != '0),
    "no digits left while emitting")
  `N2A_ASSERT_NEXT(a_last_idle, push && (state == ST_DIG) && (left == LeftW'(1)),
    state == ST_IDLE, "not idle after last character")
  `N2A_ASSERT_NEXT(a_take_busy, start, bcd_st.busy, "converter not started on decimal request")

endmodule

>>> hdl/n2a_bcd.sv
// Bit-serial binary to BCD converter (shift and add three).
`include "number_to_ascii_formatter_macros.svh"

module n2a_bcd (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [n2a_pkg::ValueW-1:0]   bin_in,
  output logic [n2a_pkg::BcdW-1:0]     bcd,
  output n2a_pkg::bcd_stat_t           stat
);
  import n2a_pkg::*;

  logic [ValueW-1:0]  bin;
  logic [BitCntW-1:0] bits;
  logic               busy;
  logic               done;
  logic [BcdW-1:0]    adj;

  always_comb begin
    adj = bcd;
    for (int i = 0; i < DecDigits; i++) begin
      if (bcd[i*DigitW +: DigitW] >= 4'd5) begin
        adj[i*DigitW +: DigitW] = bcd[i*DigitW +: DigitW] + 4'd3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      bits <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        bits <= BitCntW'(ValueW);
      end else if (busy) begin
        bits <= bits - 1'b1;
        if (bits == BitCntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      bin <= bin_in;
      bcd <= '0;
    end else if (busy) begin
      bin <= {bin[ValueW-2:0], 1'b0};
      bcd <= {adj[BcdW-2:0], bin[ValueW-1]};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

  `N2A_ASSERT_NEXT(a_done_idle, done, !busy, "converter still busy after done")
  `N2A_ASSERT(a_idle_bits, !busy |-> (bits == '0), "bit count left over while idle")
  `N2A_ASSERT(a_busy_bits, busy |-> (bits != '0), "converter busy with no bits left")

endmodule

>>> hdl/n2a_oreg.sv
// Output register holding one character until the sink takes it.
module n2a_oreg (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  n2a_pkg::char_t   data,
  output logic             room,
  n2a_out_if.source        text
);
  import n2a_pkg::*;

  assign room = !text.valid || text.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      text.valid <= 1'b0;
    end else if (room) begin
      text.valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (push && room) begin
      text.char_code <= data.char_code;
      text.last_char <= data.last_char;
    end
  end

endmodule

>>> tb/number_to_ascii_formatter_tb.sv
// Self-checking testbench for number_to_ascii_formatter: directed and random numbers, all kinds.
`timescale 1ns / 100ps

module number_to_ascii_formatter_tb;
  import n2a_pkg::*;

  localparam logic [KindW-1:0] KIND_NONE = 2'd3;
  localparam int IdleLimit = 4000;
  localparam int HoldCycles = 400;
  localparam int RandomNumbers = 330;
  localparam int DrainCycles = 60;

  class char_tracker;
    char_t       pending_chars[$];
    int unsigned errors;
    int unsigned numbers_seen;
    int unsigned silent_numbers;
    int unsigned chars_seen;

    function void note_number(logic [KindW-1:0] kind, logic [ValueW-1:0] value,
                              logic prefix, logic [CountW-1:0] count);
      logic [CharW-1:0] txt[$];
      logic [DigitW-1:0] digits[DecDigits];
      logic [ValueW-1:0] mag;
      logic [DigitW-1:0] nib;
      char_t             c;
      int                top;
      int                width;
      numbers_seen++;
      mag = value;
      case (kind)
        KIND_DEC: begin
          if (value[ValueW-1]) begin
            txt.push_back(CH_MINUS);
            mag = -value;
          end
          for (int i = 0; i < DecDigits; i++) begin
            digits[i] = DigitW'(mag % 10);
            mag = mag / 10;
          end
          top = DecDigits - 1;
          while (top > 0 && digits[top] == 0) top--;
          for (int i = top; i >= 0; i--) txt.push_back(CH_ZERO + CharW'(digits[i]));
        end
        KIND_HEX: begin
          if (prefix) begin
            txt.push_back(CH_ZERO);
            txt.push_back(CH_X);
          end
          top = HexDigits - 1;
          while (top > 0 && value[DigitW*top +: DigitW] == 0) top--;
          for (int i = top; i >= 0; i--) begin
            nib = value[DigitW*i +: DigitW];
            if (nib < 10) txt.push_back(CH_ZERO + CharW'(nib));
            else txt.push_back(CH_UPPER_A + CharW'(nib - 10));
          end
        end
        KIND_FIX: begin
          width = (count == 0) ? 1 : (count > DecDigits) ? DecDigits : int'(count);
          for (int i = 0; i < DecDigits; i++) begin
            digits[i] = DigitW'(mag % 10);
            mag = mag / 10;
          end
          for (int i = width - 1; i >= 0; i--) txt.push_back(CH_ZERO + CharW'(digits[i]));
        end
        default: silent_numbers++;
      endcase
      foreach (txt[k]) begin
        c.char_code = txt[k];
        c.last_char = (k == txt.size() - 1);
        pending_chars.push_back(c);
      end
    endfunction

    function void check_char(logic [CharW-1:0] code, logic last);
      char_t want;
      chars_seen++;
      if (pending_chars.size() == 0) begin
        $display("%0t ns: char with none expected: expected nothing, actual code %h last %b",
                 $time, code, last);
        errors++;
        return;
      end
      want = pending_chars.pop_front();
      if (want.char_code !== code) begin
        $display("%0t ns: char_code mismatch: expected %h, actual %h",
                 $time, want.char_code, code);
        errors++;
      end
      if (want.last_char !== last) begin
        $display("%0t ns: last_char mismatch: expected %b, actual %b",
                 $time, want.last_char, last);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  n2a_in_if  number_bus ();
  n2a_out_if text_bus ();

  number_to_ascii_formatter uut (
    .clk    (clk),
    .rst    (rst),
    .number (number_bus),
    .text   (text_bus)
  );

  char_tracker tracker = new();

  bit tx_idle_on;
  bit rx_idle_on;
  bit hold_text;
  int idle_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && number_bus.valid && number_bus.ready) begin
      tracker.note_number(number_bus.kind, number_bus.value, number_bus.hex_prefix,
                          number_bus.digit_count);
    end
    if (!rst && text_bus.valid && text_bus.ready) begin
      tracker.check_char(text_bus.char_code, text_bus.last_char);
    end
    if ((number_bus.valid && number_bus.ready) || (text_bus.valid && text_bus.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("%0t ns: no request moved for %0d cycles", $time, IdleLimit);
        $display("** number_to_ascii_formatter: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    text_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_text) begin
        text_bus.ready <= 1'b0;
        repeat (HoldCycles - 1) @(negedge clk);
        hold_text = 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 9) == 0) begin
        text_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 18) - 1) @(negedge clk);
      end else begin
        text_bus.ready <= 1'b1;
      end
    end
  end

  task automatic send_number(input logic [KindW-1:0] kind, input logic [ValueW-1:0] value,
                             input logic prefix, input logic [CountW-1:0] count);
    number_bus.valid       <= 1'b1;
    number_bus.kind        <= kind;
    number_bus.value       <= value;
    number_bus.hex_prefix  <= prefix;
    number_bus.digit_count <= count;
    @(posedge clk);
    while (!number_bus.ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [ValueW-1:0] pick_value();
    logic [ValueW-1:0] t;
    int unsigned       p;
    t = 1;
    case ($urandom_range(0, 5))
      0: t = $urandom;
      1: t = $urandom_range(0, 20);
      2: begin
        p = $urandom_range(0, 9);
        repeat (p) t = t * 10;
        t = t + $urandom_range(0, 2) - 1;
      end
      3: t = $urandom >> $urandom_range(0, 31);
      4: t = -$urandom_range(1, 1000);
      default: begin
        case ($urandom_range(0, 3))
          0: t = 32'h0000_0000;
          1: t = 32'h7FFF_FFFF;
          2: t = 32'h8000_0000;
          default: t = 32'hFFFF_FFFF;
        endcase
      end
    endcase
    return t;
  endfunction

  initial begin
    logic [KindW-1:0] kind;
    int unsigned      pick;
    idle_cycles = 0;
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    hold_text = 1'b0;
    rst = 1'b1;
    number_bus.valid = 1'b0;
    number_bus.kind = KIND_DEC;
    number_bus.value = '0;
    number_bus.hex_prefix = 1'b0;
    number_bus.digit_count = '0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_number(KIND_DEC, 32'd0, 1'b0, 4'd0);
    send_number(KIND_DEC, 32'd1, 1'b0, 4'd0);
    send_number(KIND_DEC, 32'h7FFF_FFFF, 1'b0, 4'd0);
    send_number(KIND_DEC, 32'h8000_0000, 1'b0, 4'd0);
    send_number(KIND_DEC, 32'hFFFF_FFFF, 1'b0, 4'd0);
    send_number(KIND_DEC, 32'h8000_0001, 1'b1, 4'd15);
    send_number(KIND_DEC, 32'd1000000000, 1'b0, 4'd7);
    send_number(KIND_DEC, 32'd999999999, 1'b1, 4'd3);
    send_number(KIND_HEX, 32'h0, 1'b0, 4'd0);
    send_number(KIND_HEX, 32'h0, 1'b1, 4'd0);
    send_number(KIND_HEX, 32'hFFFF_FFFF, 1'b1, 4'd15);
    send_number(KIND_HEX, 32'h0000_000A, 1'b0, 4'd10);
    send_number(KIND_HEX, 32'h89AB_CDEF, 1'b0, 4'd0);
    send_number(KIND_HEX, 32'h1000_0000, 1'b1, 4'd5);
    send_number(KIND_FIX, 32'd0, 1'b0, 4'd0);
    send_number(KIND_FIX, 32'hFFFF_FFFF, 1'b0, 4'd10);
    send_number(KIND_FIX, 32'hFFFF_FFFF, 1'b1, 4'd15);
    send_number(KIND_FIX, 32'd1234567, 1'b0, 4'd1);
    send_number(KIND_FIX, 32'd42, 1'b0, 4'd11);
    send_number(KIND_FIX, 32'd7, 1'b1, 4'd5);
    send_number(KIND_FIX, 32'd4294967295, 1'b0, 4'd9);
    send_number(KIND_NONE, 32'hDEAD_BEEF, 1'b1, 4'd15);
    send_number(KIND_NONE, 32'h0, 1'b0, 4'd0);

    for (int i = 0; i < RandomNumbers; i++) begin
      tx_idle_on = (i < 100) || (i >= 140 && i < 260);
      rx_idle_on = tx_idle_on;
      if (i == 100) hold_text = 1'b1;
      pick = $urandom_range(0, 19);
      kind = (pick < 6) ? KIND_DEC : (pick < 12) ? KIND_HEX : (pick < 18) ? KIND_FIX : KIND_NONE;
      send_number(kind, pick_value(), 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
      if (tx_idle_on && $urandom_range(0, 4) == 0) begin
        number_bus.valid <= 1'b0;
        repeat ($urandom_range(1, 18)) @(negedge clk);
      end
    end
    number_bus.valid <= 1'b0;

    while (tracker.pending_chars.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Formatted %0d numbers (%0d of the unused kind) into %0d characters,",
             tracker.numbers_seen, tracker.silent_numbers, tracker.chars_seen);
    $display("with idle bursts on both sides and one long output stall; %0d mismatches.",
             tracker.errors);
    if (tracker.errors == 0) begin
      $display("** number_to_ascii_formatter: PASSED **");
    end else begin
      $display("** number_to_ascii_formatter: FAILED **");
    end
    $finish;
  end

endmodule
